>>> src/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// request and status codes and field widths shared by the thread scheduler
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam int REQ_W    = 2;
	localparam int TID_W    = 7;
	localparam int STATUS_W = 3;
	localparam int RES_W    = 6;

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE = 2'd0,
		REQ_YIELD  = 2'd1,
		REQ_EXIT   = 2'd2,
		REQ_KILL   = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_NONE    = 3'd2,
		ST_NOFREE  = 3'd3,
		ST_HALTED  = 3'd4
	} status_t;

	// special target ids
	localparam logic signed [TID_W-1:0] TID_ANY  = -7'sd1;
	localparam logic signed [TID_W-1:0] TID_SELF = -7'sd2;

endpackage

>>> src/fts_if.sv
// ----------------------------------------------------------------------------
// fts_req_if / fts_rsp_if
// valid/ready channels for scheduler requests and their results
// ----------------------------------------------------------------------------
interface fts_req_if;
	import fts_pkg::*;

	logic                     valid;
	logic                     ready;
	req_type_t                req_type;
	logic signed [TID_W-1:0]  target_tid;

	modport source (output valid, req_type, target_tid, input ready);
	modport sink   (input valid, req_type, target_tid, output ready);
endinterface

interface fts_rsp_if;
	import fts_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [RES_W-1:0]  result_tid;
	logic [RES_W-1:0]  running_tid;

	modport source (output valid, status, result_tid, running_tid, input ready);
	modport sink   (input valid, status, result_tid, running_tid, output ready);
endinterface

>>> src/fifo_thread_scheduler.sv
// ----------------------------------------------------------------------------
// fifo_thread_scheduler
// one item at a time; kill, exit with an empty list and the fast yield cases
// go straight to the result, create scans the allocation map one id per cycle,
// yield to an id walks the link memory one entry per cycle, each killed thread
// met on a switch is freed and the next list head is taken; the result is
// registered and the next item is taken while it waits. reset: thread 0
// running, list empty; link memory not cleared
// ----------------------------------------------------------------------------
module fifo_thread_scheduler #(
	parameter int MAX_THREADS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	fts_req_if.sink     req,
	fts_rsp_if.source   rsp
);
	import fts_pkg::*;

	localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = $clog2(MAX_THREADS + 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_WALK   = 8'b0000_0100,
		S_UNLINK = 8'b0000_1000,
		S_APPEND = 8'b0001_0000,
		S_SWITCH = 8'b0010_0000,
		S_HEAD   = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t                  state_q, nxt_q;
	logic [MAX_THREADS-1:0]  alloc_q, kill_q;
	logic [TW-1:0]           head_q, tail_q, run_q;
	logic [CW-1:0]           cnt_q, n_q;
	req_type_t               req_q;
	logic [TW-1:0]           tgt_q, scan_q, cur_q, prev_q, h_q, res_q;
	logic                    from_mem_q, run_alloc_q;
	status_t                 status_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [RES_W-1:0]        out_res_q, out_run_q;

	// link memory
	logic [TW-1:0]           link_mem [MAX_THREADS];
	logic [TW-1:0]           link_rd_q;
	logic                    rd_en, wr_en;
	logic [TW-1:0]           rd_addr, wr_addr, wr_data;

	// request decode
	int                      t_int;
	logic                    t_self, t_any, t_low, t_big, t_pos;
	logic [TW-1:0]           t_id;
	logic                    run_alloc, q_empty, head_more;
	logic [TW-1:0]           cur_w, app_id;
	state_t                  after_pop;

	assign t_int     = int'(req.target_tid);
	assign t_self    = (req.target_tid == TID_SELF);
	assign t_any     = (req.target_tid == TID_ANY);
	assign t_low     = (t_int < -2);
	assign t_big     = (t_int >= MAX_THREADS);
	assign t_pos     = !req.target_tid[TID_W-1];
	assign t_id      = t_int[TW-1:0];
	assign run_alloc = alloc_q[run_q];
	assign q_empty   = (cnt_q == '0);
	assign head_more = (cnt_q > CW'(1));
	assign cur_w     = from_mem_q ? link_rd_q : cur_q;
	assign app_id    = (req_q == REQ_CREATE) ? scan_q : run_q;
	assign after_pop = run_alloc ? S_APPEND : S_SWITCH;

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.result_tid  = out_res_q;
	assign rsp.running_tid = out_run_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = app_id;
		unique case (state_q)
			S_IDLE, S_SWITCH: begin
				rd_en = 1'b1;
			end
			S_WALK: begin
				rd_en   = 1'b1;
				rd_addr = cur_w;
			end
			S_APPEND: begin
				wr_en = !q_empty;
			end
			S_UNLINK: begin
				wr_en   = (n_q != '0);
				wr_addr = prev_q;
				wr_data = link_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			link_mem[wr_addr] <= wr_data;
		if (rd_en)
			link_rd_q <= link_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			nxt_q        <= S_IDLE;
			alloc_q      <= MAX_THREADS'(1);
			kill_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			run_q        <= '0;
			n_q          <= '0;
			req_q        <= REQ_CREATE;
			tgt_q        <= '0;
			scan_q       <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
			h_q          <= '0;
			res_q        <= '0;
			from_mem_q   <= 1'b0;
			run_alloc_q  <= 1'b0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_res_q    <= '0;
			out_run_q    <= '0;
		end else begin
			if (rsp.ready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q       <= req.req_type;
						tgt_q       <= t_id;
						run_alloc_q <= run_alloc;
						unique case (req.req_type)
							REQ_CREATE: begin
								res_q    <= '0;
								status_q <= ST_OK;
								scan_q   <= '0;
								state_q  <= S_SCAN;
							end
							REQ_YIELD: begin
								if (t_low || t_big) begin
									res_q    <= '0;
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else if (t_any && q_empty) begin
									res_q    <= '0;
									status_q <= ST_NONE;
									state_q  <= S_FIN;
								end else if (t_pos && !alloc_q[t_id]) begin
									res_q    <= '0;
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else if (t_self || (t_pos && t_id == run_q)) begin
									res_q    <= run_q;
									status_q <= ST_OK;
									state_q  <= S_FIN;
								end else if (t_any) begin
									h_q      <= head_q;
									res_q    <= head_q;
									status_q <= ST_OK;
									cnt_q    <= cnt_q - CW'(1);
									nxt_q    <= after_pop;
									state_q  <= head_more ? S_HEAD : after_pop;
								end else begin
									res_q      <= '0;
									status_q   <= ST_OK;
									cur_q      <= head_q;
									from_mem_q <= 1'b0;
									n_q        <= '0;
									state_q    <= S_WALK;
								end
							end
							REQ_EXIT: begin
								if (run_alloc) begin
									alloc_q[run_q] <= 1'b0;
									kill_q[run_q]  <= 1'b0;
								end
								if (q_empty) begin
									res_q    <= '0;
									status_q <= ST_HALTED;
									state_q  <= S_FIN;
								end else begin
									h_q      <= head_q;
									res_q    <= head_q;
									status_q <= ST_OK;
									cnt_q    <= cnt_q - CW'(1);
									nxt_q    <= S_SWITCH;
									state_q  <= head_more ? S_HEAD : S_SWITCH;
								end
							end
							REQ_KILL: begin
								state_q <= S_FIN;
								if (t_self || t_low || t_big || q_empty ||
								    (t_pos && (t_id == run_q || !alloc_q[t_id]))) begin
									res_q    <= '0;
									status_q <= ST_INVALID;
								end else if (t_any) begin
									res_q          <= head_q;
									status_q       <= ST_OK;
									kill_q[head_q] <= 1'b1;
								end else begin
									res_q        <= t_id;
									status_q     <= ST_OK;
									kill_q[t_id] <= 1'b1;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!alloc_q[scan_q]) begin
						alloc_q[scan_q] <= 1'b1;
						kill_q[scan_q]  <= 1'b0;
						res_q           <= scan_q;
						state_q         <= S_APPEND;
					end else if (scan_q == TW'(MAX_THREADS - 1)) begin
						status_q <= ST_NOFREE;
						state_q  <= S_FIN;
					end else begin
						scan_q <= scan_q + TW'(1);
					end
				end
				S_APPEND: begin
					if (q_empty)
						head_q <= app_id;
					tail_q <= app_id;
					if (cnt_q < CW'(MAX_THREADS))
						cnt_q <= cnt_q + CW'(1);
					state_q <= (req_q == REQ_CREATE) ? S_FIN : S_SWITCH;
				end
				S_WALK: begin
					if (n_q == cnt_q) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else if (cur_w == tgt_q) begin
						cur_q   <= cur_w;
						state_q <= S_UNLINK;
					end else begin
						prev_q     <= cur_w;
						from_mem_q <= 1'b1;
						n_q        <= n_q + CW'(1);
					end
				end
				S_UNLINK: begin
					cnt_q <= cnt_q - CW'(1);
					h_q   <= cur_q;
					res_q <= cur_q;
					if (n_q == '0) begin
						if (head_more)
							head_q <= link_rd_q;
					end else if (cur_q == tail_q) begin
						tail_q <= prev_q;
					end
					state_q <= run_alloc_q ? S_APPEND : S_SWITCH;
				end
				S_SWITCH: begin
					if (!kill_q[h_q]) begin
						run_q    <= h_q;
						status_q <= ST_OK;
						state_q  <= S_FIN;
					end else begin
						alloc_q[h_q] <= 1'b0;
						kill_q[h_q]  <= 1'b0;
						if (q_empty) begin
							run_q    <= h_q;
							status_q <= ST_HALTED;
							state_q  <= S_FIN;
						end else begin
							h_q   <= head_q;
							cnt_q <= cnt_q - CW'(1);
							if (head_more) begin
								nxt_q   <= S_SWITCH;
								state_q <= S_HEAD;
							end
						end
					end
				end
				S_HEAD: begin
					head_q  <= link_rd_q;
					state_q <= nxt_q;
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_res_q    <= RES_W'(res_q);
						out_run_q    <= RES_W'(run_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_THREADS))
		else $error("ready list count above thread count");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> n_q <= cnt_q)
		else $error("list walk past the queue length");

	a_create_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && !alloc_q[scan_q] |=> alloc_q[$past(scan_q)])
		else $error("created id not allocated");

	a_switch_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWITCH && !kill_q[h_q] |=> run_q == $past(h_q))
		else $error("switch did not update the running id");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("link memory read and write in one cycle");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives create, yield, exit and kill requests into the thread scheduler and
// compares every result item with a cycle-free model of the allocation map,
// linked ready list, kill marks and running id kept in a scoreboard class.
// a directed sequence covers the corner cases, then random traffic with
// creation sprees and random idling on both channels, and one long
// result hold-off that backs up the request channel
// ----------------------------------------------------------------------------
module tb;
	import fts_pkg::*;

	localparam int THREADS = 64;

	typedef struct packed {
		bit [THREADS-1:0]       alloc;
		bit [THREADS-1:0]       kill;
		bit [THREADS-1:0]       link_set;
		bit [THREADS-1:0][5:0]  link;
		bit [5:0]               head;
		bit [5:0]               tail;
		bit [6:0]               count;
		bit [5:0]               running;
	} sched_state_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  result_tid;
		logic [5:0]  running_tid;
	} sched_reply_t;

	class sched_scoreboard;
		sched_state_t  st;
		sched_reply_t  expected_replies[$];
		int unsigned   mismatches;

		function new();
			st = '0;
			st.alloc[0] = 1'b1;
			mismatches = 0;
		endfunction

		function void enqueue(inout sched_state_t s, input bit [5:0] id);
			if (s.count == 0) begin
				s.head = id;
			end else begin
				s.link[s.tail] = id;
				s.link_set[s.tail] = 1'b1;
			end
			s.tail = id;
			if (s.count < THREADS)
				s.count++;
		endfunction

		function bit [5:0] dequeue(inout sched_state_t s, inout bit unset_read);
			bit [5:0] id;
			id = s.head;
			if (s.count > 0)
				s.count--;
			if (s.count > 0) begin
				if (!s.link_set[id])
					unset_read = 1'b1;
				s.head = s.link[id];
			end
			return id;
		endfunction

		// marked threads met on the way are freed and the next head is taken
		function status_t run_chosen(inout sched_state_t s, input bit [5:0] id,
				inout bit unset_read);
			int n;
			for (n = 0; n <= THREADS; n++) begin
				if (!s.kill[id]) begin
					s.running = id;
					return ST_OK;
				end
				s.alloc[id] = 1'b0;
				s.kill[id] = 1'b0;
				if (s.count == 0) begin
					s.running = id;
					return ST_HALTED;
				end
				id = dequeue(s, unset_read);
			end
			s.running = id;
			return ST_OK;
		endfunction

		function void apply_request(inout sched_state_t s, input req_type_t rq,
				input logic signed [6:0] t, output sched_reply_t r,
				output bit unset_read);
			bit [5:0] run, h, cur, prev, id, res;
			bit run_alloc, found;
			status_t status;
			int i, n;
			unset_read = 1'b0;
			run = s.running;
			run_alloc = s.alloc[run];
			status = ST_OK;
			res = '0;
			h = '0;
			id = t[5:0];
			case (rq)
				REQ_CREATE: begin
					found = 1'b0;
					for (i = 0; i < THREADS && !found; i++)
						if (!s.alloc[i]) begin
							found = 1'b1;
							h = 6'(i);
						end
					if (!found) begin
						status = ST_NOFREE;
					end else begin
						s.alloc[h] = 1'b1;
						s.kill[h] = 1'b0;
						enqueue(s, h);
						res = h;
					end
				end
				REQ_YIELD: begin
					if (t < TID_SELF) begin
						status = ST_INVALID;
					end else if (t == TID_ANY && s.count == 0) begin
						status = ST_NONE;
					end else if (!t[6] && !s.alloc[id]) begin
						status = ST_INVALID;
					end else if (t == TID_SELF || (!t[6] && id == run)) begin
						res = run;
					end else begin
						if (t == TID_ANY) begin
							h = dequeue(s, unset_read);
						end else begin
							h = id;
							found = 1'b0;
							cur = s.head;
							prev = '0;
							for (n = 0; n < s.count && !found; n++) begin
								if (cur == h) begin
									found = 1'b1;
									if (n == 0) begin
										void'(dequeue(s, unset_read));
									end else begin
										s.link[prev] = s.link[cur];
										s.link_set[prev] = s.link_set[cur];
										if (cur == s.tail)
											s.tail = prev;
										s.count--;
									end
								end else begin
									prev = cur;
									if (n + 1 < s.count) begin
										if (!s.link_set[cur])
											unset_read = 1'b1;
										cur = s.link[cur];
									end
								end
							end
							if (!found)
								status = ST_INVALID;
						end
						if (status == ST_OK) begin
							if (run_alloc)
								enqueue(s, run);
							res = h;
							status = run_chosen(s, h, unset_read);
						end
					end
				end
				REQ_EXIT: begin
					if (run_alloc) begin
						s.alloc[run] = 1'b0;
						s.kill[run] = 1'b0;
					end
					if (s.count == 0) begin
						status = ST_HALTED;
					end else begin
						h = dequeue(s, unset_read);
						res = h;
						status = run_chosen(s, h, unset_read);
					end
				end
				default: begin
					if (t <= TID_SELF || (!t[6] && (id == run || !s.alloc[id])) ||
					    s.count == 0) begin
						status = ST_INVALID;
					end else begin
						res = (t == TID_ANY) ? s.head : id;
						s.kill[res] = 1'b1;
					end
				end
			endcase
			if (status == ST_INVALID || status == ST_NONE || status == ST_NOFREE)
				res = '0;
			r.status = status;
			r.result_tid = res;
			r.running_tid = s.running;
		endfunction

		function void note_request(req_type_t rq, logic signed [6:0] t);
			sched_reply_t r;
			bit unset_read;
			apply_request(st, rq, t, r, unset_read);
			expected_replies.push_back(r);
		endfunction

		function bit keeps_links_defined(req_type_t rq, logic signed [6:0] t);
			sched_state_t trial;
			sched_reply_t r;
			bit unset_read;
			trial = st;
			apply_request(trial, rq, t, r, unset_read);
			return !unset_read;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function void check_result(status_t status, logic [5:0] result_tid,
				logic [5:0] running_tid);
			sched_reply_t e;
			if (expected_replies.size() == 0) begin
				$error("result item with no request pending");
				mismatches++;
				return;
			end
			e = expected_replies.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				mismatches++;
			end
			if (result_tid !== e.result_tid) begin
				$error("result_tid: expected %0d, got %0d", e.result_tid, result_tid);
				mismatches++;
			end
			if (running_tid !== e.running_tid) begin
				$error("running_tid: expected %0d, got %0d", e.running_tid, running_tid);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fts_req_if req_ch();
	fts_rsp_if rsp_ch();

	fifo_thread_scheduler #(
		.MAX_THREADS(THREADS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	sched_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("tb failed");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.result_tid, rsp_ch.running_tid);
	end

	task automatic offer(input req_type_t rq, input logic signed [6:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = rq;
		req_ch.target_tid = t;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(rq, t);
		@(negedge clk);
	endtask

	function automatic req_type_t pick_request();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return REQ_CREATE;
		if (r < 65)
			return REQ_YIELD;
		if (r < 85)
			return REQ_KILL;
		return REQ_EXIT;
	endfunction

	function automatic logic signed [6:0] pick_target();
		logic signed [6:0] pick;
		int r, k, base, idx;
		r = $urandom_range(99);
		if (r < 25)
			return TID_ANY;
		if (r < 35)
			return TID_SELF;
		if (r < 45) begin
			pick = 7'(sb.st.running);
			return pick;
		end
		if (r < 85) begin
			base = $urandom_range(THREADS - 1);
			for (k = 0; k < THREADS; k++) begin
				idx = (base + k) % THREADS;
				if (sb.st.alloc[idx]) begin
					pick = 7'(idx);
					return pick;
				end
			end
			return TID_ANY;
		end
		if (r < 93)
			pick = 7'($urandom_range(THREADS - 1));
		else
			pick = 7'($urandom_range(127));
		return pick;
	endfunction

	initial begin
		req_type_t rq;
		logic signed [6:0] t;
		int phase, i, tries, spree;

		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CREATE;
		req_ch.target_tid = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner cases from reset
		offer(REQ_YIELD, TID_ANY);
		offer(REQ_KILL, TID_ANY);
		offer(REQ_CREATE, 7'sd0);
		offer(REQ_CREATE, -7'sd1);
		offer(REQ_CREATE, 7'sd63);
		offer(REQ_YIELD, TID_SELF);
		offer(REQ_YIELD, 7'sd0);
		offer(REQ_YIELD, 7'sd63);
		offer(REQ_YIELD, -7'sd64);
		offer(REQ_KILL, TID_SELF);
		offer(REQ_KILL, 7'sd0);
		offer(REQ_KILL, -7'sd64);
		offer(REQ_KILL, 7'sd63);
		offer(REQ_YIELD, 7'sd3);
		offer(REQ_KILL, TID_ANY);
		offer(REQ_KILL, 7'sd2);
		offer(REQ_YIELD, TID_ANY);
		offer(REQ_EXIT, 7'sd0);
		offer(REQ_EXIT, -7'sd64);
		offer(REQ_YIELD, TID_SELF);
		offer(REQ_YIELD, TID_ANY);
		offer(REQ_CREATE, 7'sd0);
		offer(REQ_KILL, 7'sd0);
		offer(REQ_YIELD, TID_ANY);
		offer(REQ_CREATE, 7'sd0);
		offer(REQ_EXIT, 7'sd0);

		spree = 0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off = 400; end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			for (i = 0; i < 500; i++) begin
				if (spree > 0) begin
					rq = REQ_CREATE;
					t = 7'($urandom_range(127));
					spree--;
				end else begin
					if ($urandom_range(99) < 2)
						spree = $urandom_range(70, 20);
					tries = 0;
					do begin
						rq = pick_request();
						if (rq == REQ_CREATE || rq == REQ_EXIT)
							t = 7'($urandom_range(127));
						else
							t = pick_target();
						tries++;
					end while (!sb.keeps_links_defined(rq, t) && tries < 20);
					if (!sb.keeps_links_defined(rq, t))
						rq = REQ_CREATE;
				end
				offer(rq, t);
			end
		end
		req_ch.valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
